@@ rtl/xkd_pkg.sv @@
// Shared types, constants and the mixing function of the XXTEA keystream decrypt unit.
package xkd_pkg;

	localparam logic [31:0] MIX_DELTA = 32'h9e3779b9;

	// Configuration register indexes
	localparam logic [1:0] REG_KEY_A = 2'd0;
	localparam logic [1:0] REG_KEY_B = 2'd1;
	localparam logic [1:0] REG_KEY_C = 2'd2;
	localparam logic [1:0] REG_KEY_D = 2'd3;

	// Commands from controller to datapath
	typedef struct packed {
		logic latch;       // capture the accepted item
		logic build_init;  // restart table expansion counters
		logic bld_rd_cur;  // read table word at the build pointer
		logic bld_rd_nxt;  // read the neighbor word, hold the current one
		logic bld_write;   // write the mixed word, advance the pointer
		logic word_rd;     // read the keystream word for the held item
		logic commit;      // load result registers, update file state
	} xkd_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic key_absent;
		logic build_last;
	} xkd_stat_t;

	// One XXTEA mixing step on a word pair
	function automatic logic [31:0] mix(input logic [31:0] z, input logic [31:0] y,
			input logic [31:0] sum, input logic [31:0] k);
		logic [31:0] a;
		logic [31:0] b;
		a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
		b = (sum ^ y) + (k ^ z);
		return a ^ b;
	endfunction

endpackage

@@ rtl/xkd_ctrl.sv @@
// Controller state machine: accept, table expansion sequence, word read, result load.
module xkd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic             cfg_valid,
	input  xkd_pkg::xkd_stat_t stat,
	output xkd_pkg::xkd_cmd_t  cmd
);
	import xkd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_BLD0, S_BLD1, S_BLD2, S_RD, S_DONE
	} state_t;

	state_t state_q;
	logic   table_ready_q;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// Decode commands from state
	always_comb begin
		cmd            = '0;
		cmd.latch      = accept;
		cmd.build_init = accept && !stat.key_absent && !table_ready_q;
		cmd.bld_rd_cur = (state_q == S_BLD0);
		cmd.bld_rd_nxt = (state_q == S_BLD1);
		cmd.bld_write  = (state_q == S_BLD2);
		cmd.word_rd    = (state_q == S_RD);
		cmd.commit     = (state_q == S_DONE) && slot_free;
	end

	// Hold state, table status and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			table_ready_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				table_ready_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (stat.key_absent) begin
							state_q <= S_DONE;
						end else if (!table_ready_q) begin
							state_q <= S_BLD0;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_BLD0: state_q <= S_BLD1;
				S_BLD1: state_q <= S_BLD2;
				S_BLD2: begin
					if (stat.build_last) begin
						table_ready_q <= 1'b1;
						state_q       <= S_RD;
					end else begin
						state_q <= S_BLD0;
					end
				end
				S_RD: state_q <= S_DONE;
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/xkd_datapath.sv @@
// Datapath: key registers, table memory, expansion mixer, per-word XOR and checksum.
module xkd_datapath #(
	parameter int TABLE_WORDS = 1024,
	parameter int FULL_WORDS  = 512,
	parameter int STRIDE      = 64,
	parameter int SUM_WORDS   = 128,
	parameter int ROUNDS      = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  xkd_pkg::xkd_cmd_t  cmd,
	output xkd_pkg::xkd_stat_t stat,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [31:0]        cipher_word,
	input  logic               first_of_file,
	input  logic               last_of_file,
	input  logic [31:0]        expected_sum,
	output logic [31:0]        plain_word,
	output logic               end_of_file,
	output logic               key_absent,
	output logic               sum_matches
);
	import xkd_pkg::*;

	localparam int POS_CAP = (FULL_WORDS > SUM_WORDS) ? FULL_WORDS : SUM_WORDS;
	localparam int IW = $clog2(TABLE_WORDS);
	localparam int PW = $clog2(POS_CAP + 1);
	localparam int SW = (STRIDE > 1) ? $clog2(STRIDE) : 1;
	localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
	localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_WORDS - 1);

	logic [31:0] mem [TABLE_WORDS];
	logic [31:0] rdata_q;
	logic [IW-1:0] raddr;
	logic          rd_en;

	logic [31:0] key_q [4];
	logic [PW-1:0] pos_q;
	logic [SW-1:0] ph_q;
	logic [IW-1:0] idx_q;
	logic [31:0]   rsum_q;
	logic [31:0]   hexp_q;

	logic [31:0] cw_q;
	logic        first_q;
	logic        last_q;
	logic [31:0] exp_q;

	logic [IW-1:0] p_q;
	logic [RW-1:0] rnd_q;
	logic [31:0]   bsum_q;
	logic [31:0]   z_q;
	logic [31:0]   cur_q;

	logic          round0;
	logic [IW-1:0] p_next;
	logic [31:0]   y_word;
	logic [1:0]    ksel;
	logic [31:0]   new_word;

	logic [PW-1:0] e_pos;
	logic [SW-1:0] e_ph;
	logic [IW-1:0] e_idx;
	logic [31:0]   e_rsum;
	logic [31:0]   e_hexp;
	logic          full;
	logic          do_xor;
	logic [31:0]   plain;
	logic [31:0]   n_rsum;

	assign stat.key_absent = (key_q[0] == '0) || (key_q[1] == '0) ||
		(key_q[2] == '0) || (key_q[3] == '0);
	assign stat.build_last = (p_q == IDX_LAST) && (rnd_q == RW'(ROUNDS - 1));

	// Expansion mixer
	assign round0   = (rnd_q == '0);
	assign p_next   = (p_q == IDX_LAST) ? '0 : p_q + 1'b1;
	assign y_word   = (round0 && p_q != IDX_LAST) ? '0 : rdata_q;
	assign ksel     = p_q[1:0] ^ bsum_q[3:2];
	assign new_word = cur_q + mix(z_q, y_word, bsum_q, key_q[ksel]);

	// File position with a first mark applied
	assign e_pos  = first_q ? '0 : pos_q;
	assign e_ph   = first_q ? '0 : ph_q;
	assign e_idx  = first_q ? '0 : idx_q;
	assign e_rsum = first_q ? '0 : rsum_q;
	assign e_hexp = first_q ? exp_q : hexp_q;
	assign full   = (e_pos < PW'(FULL_WORDS));
	assign do_xor = full || (e_ph == '0);
	assign plain  = do_xor ? (cw_q ^ rdata_q) : cw_q;
	assign n_rsum = (e_pos < PW'(SUM_WORDS)) ? (e_rsum ^ plain) : e_rsum;

	// Table read address
	assign rd_en = cmd.bld_rd_cur || cmd.bld_rd_nxt || cmd.word_rd;
	always_comb begin
		if (cmd.bld_rd_cur) begin
			raddr = p_q;
		end else if (cmd.bld_rd_nxt) begin
			raddr = p_next;
		end else begin
			raddr = e_idx;
		end
	end

	// Table memory
	always_ff @(posedge clk) begin
		if (cmd.bld_write) begin
			mem[p_q] <= new_word;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// Hold the accepted item and build working words
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cw_q    <= cipher_word;
			first_q <= first_of_file;
			last_q  <= last_of_file;
			exp_q   <= expected_sum;
		end
		if (cmd.build_init) begin
			z_q <= '0;
		end else if (cmd.bld_write) begin
			z_q <= new_word;
		end
		if (cmd.bld_rd_nxt) begin
			cur_q <= round0 ? '0 : rdata_q;
		end
	end

	// Advance build pointer, round and running delta
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q    <= '0;
			rnd_q  <= '0;
			bsum_q <= '0;
		end else if (cmd.build_init) begin
			p_q    <= '0;
			rnd_q  <= '0;
			bsum_q <= MIX_DELTA;
		end else if (cmd.bld_write) begin
			p_q <= p_next;
			if (p_q == IDX_LAST) begin
				rnd_q  <= rnd_q + 1'b1;
				bsum_q <= bsum_q + MIX_DELTA;
			end
		end
	end

	// Key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0] <= '0;
			key_q[1] <= '0;
			key_q[2] <= '0;
			key_q[3] <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEY_A: key_q[0] <= cfg_data;
				REG_KEY_B: key_q[1] <= cfg_data;
				REG_KEY_C: key_q[2] <= cfg_data;
				REG_KEY_D: key_q[3] <= cfg_data;
				default:   key_q[0] <= key_q[0];
			endcase
		end
	end

	// File state update on result load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			ph_q   <= '0;
			idx_q  <= '0;
			rsum_q <= '0;
			hexp_q <= '0;
		end else if (cmd.commit && !stat.key_absent) begin
			pos_q  <= (e_pos < PW'(POS_CAP)) ? e_pos + 1'b1 : e_pos;
			if (!full) begin
				ph_q <= (e_ph == SW'(STRIDE - 1)) ? '0 : e_ph + 1'b1;
			end else begin
				ph_q <= e_ph;
			end
			if (do_xor) begin
				idx_q <= (e_idx == IDX_LAST) ? '0 : e_idx + 1'b1;
			end else begin
				idx_q <= e_idx;
			end
			rsum_q <= n_rsum;
			hexp_q <= e_hexp;
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			end_of_file <= last_q;
			if (stat.key_absent) begin
				plain_word  <= '0;
				key_absent  <= 1'b1;
				sum_matches <= 1'b0;
			end else begin
				plain_word  <= plain;
				key_absent  <= 1'b0;
				sum_matches <= last_q && (n_rsum == e_hexp);
			end
		end
	end

endmodule

@@ rtl/xxtea_keystream_word_decrypt_unit.sv @@
// Top level of the XXTEA keystream word decrypt unit.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | cipher_word, first_of_file, last_of_file, expected_sum
//  out     | out_valid/ out_ready | plain_word, end_of_file, key_absent, sum_matches
//  cfg     | cfg_valid/ cfg_ready | cfg_index (key register), cfg_data
//
// With the table built, a word goes through accept, table read and result load.
// The first word after reset or a key write first expands the table over the single
// memory port: read word, read neighbor, write mixed word, for each word and round.
// Reset clears control, key and file state, not the table; it is rebuilt before use.
// A stalled output holds the result; the next item is taken meanwhile and waits
// for the result register to free.
module xxtea_keystream_word_decrypt_unit #(
	parameter int TABLE_WORDS = 1024,
	parameter int FULL_WORDS  = 512,
	parameter int STRIDE      = 64,
	parameter int SUM_WORDS   = 128,
	parameter int ROUNDS      = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] cipher_word,
	input  logic        first_of_file,
	input  logic        last_of_file,
	input  logic [31:0] expected_sum,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] plain_word,
	output logic        end_of_file,
	output logic        key_absent,
	output logic        sum_matches,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import xkd_pkg::*;

	xkd_cmd_t  cmd;
	xkd_stat_t stat;

	// Key writes are always taken
	assign cfg_ready = 1'b1;

	xkd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	xkd_datapath #(
		.TABLE_WORDS (TABLE_WORDS),
		.FULL_WORDS  (FULL_WORDS),
		.STRIDE      (STRIDE),
		.SUM_WORDS   (SUM_WORDS),
		.ROUNDS      (ROUNDS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cipher_word   (cipher_word),
		.first_of_file (first_of_file),
		.last_of_file  (last_of_file),
		.expected_sum  (expected_sum),
		.plain_word    (plain_word),
		.end_of_file   (end_of_file),
		.key_absent    (key_absent),
		.sum_matches   (sum_matches)
	);

endmodule

@@ rtl/xkd_checker.sv @@
// Port-level checks of the decrypt unit, bound to the top level.
module xkd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] plain_word,
	input logic        end_of_file,
	input logic        key_absent,
	input logic        sum_matches
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(plain_word))
		else $error("stalled result changed");

	// Take at most one item per word sequence
	a_no_b2b: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken in consecutive cycles");

	// Drop word and match on a missing key
	a_absent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_absent |-> plain_word == '0 && !sum_matches)
		else $error("missing key result not cleared");

	// Report a match only at the last word
	a_match_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_file |-> !sum_matches)
		else $error("match flagged before last word");

endmodule

bind xxtea_keystream_word_decrypt_unit xkd_checker u_xkd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.plain_word  (plain_word),
	.end_of_file (end_of_file),
	.key_absent  (key_absent),
	.sum_matches (sum_matches)
);

@@ sim/xxtea_keystream_word_decrypt_unit_tb.sv @@
// Testbench for the XXTEA keystream word decrypt unit: random files against a predictor.
module xxtea_keystream_word_decrypt_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import xkd_pkg::*;

	localparam int TBL_WORDS  = 1024;
	localparam int XOR_ALL    = 512;
	localparam int STEP_WORDS = 64;
	localparam int CSUM_WORDS = 128;
	localparam int MIX_ROUNDS = 6;
	localparam logic [31:0] GOLDEN = 32'h9e3779b9;

	typedef struct {
		logic [31:0] cw;
		logic        first;
		logic        last;
		logic [31:0] esum;
	} cipher_item_t;

	typedef struct {
		logic [31:0] word;
		logic        eof;
		logic        absent;
		logic        match;
	} plain_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] cipher_word = '0;
	logic        first_of_file = 1'b0;
	logic        last_of_file = 1'b0;
	logic [31:0] expected_sum = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] plain_word;
	logic        end_of_file;
	logic        key_absent;
	logic        sum_matches;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	xxtea_keystream_word_decrypt_unit DUT (.*);

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state
	logic [31:0] key_word [4];
	logic [31:0] keystream [TBL_WORDS];
	bit          keystream_built;
	logic [9:0]  file_pos;
	logic [5:0]  step_phase;
	logic [9:0]  ks_index;
	logic [31:0] csum;
	logic [31:0] csum_target;

	cipher_item_t pending_words[$];
	plain_item_t  plain_expected[$];
	int  errors = 0;
	bit  quiet = 0;
	int  hold_seq = 0;

	function automatic logic [31:0] churn(logic [31:0] z, logic [31:0] y,
			logic [31:0] s, logic [31:0] k);
		logic [31:0] a;
		logic [31:0] b;
		a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
		b = (s ^ y) + (k ^ z);
		return a ^ b;
	endfunction

	function automatic bit keys_missing();
		return key_word[0] == 0 || key_word[1] == 0 || key_word[2] == 0 || key_word[3] == 0;
	endfunction

	// Expand the key table from all zero
	function automatic void expand_keystream();
		logic [31:0] s;
		logic [31:0] y;
		logic [31:0] z;
		logic [1:0]  e;
		s = '0;
		for (int p = 0; p < TBL_WORDS; p++) keystream[p] = '0;
		z = keystream[TBL_WORDS-1];
		for (int r = 0; r < MIX_ROUNDS; r++) begin
			s += GOLDEN;
			e = s[3:2];
			for (int p = 0; p < TBL_WORDS - 1; p++) begin
				y = keystream[p+1];
				keystream[p] += churn(z, y, s, key_word[p[1:0] ^ e]);
				z = keystream[p];
			end
			y = keystream[0];
			keystream[TBL_WORDS-1] += churn(z, y, s, key_word[2'd3 ^ e]);
			z = keystream[TBL_WORDS-1];
		end
		keystream_built = 1;
	endfunction

	function automatic plain_item_t decode_word(cipher_item_t it);
		plain_item_t o;
		bit do_xor;
		o.eof = it.last;
		if (keys_missing()) begin
			o.word = '0;
			o.absent = 1'b1;
			o.match = 1'b0;
			return o;
		end
		if (!keystream_built) expand_keystream();
		if (it.first) begin
			file_pos = '0;
			step_phase = '0;
			ks_index = '0;
			csum = '0;
			csum_target = it.esum;
		end
		if (file_pos < XOR_ALL) do_xor = 1;
		else begin
			do_xor = (step_phase == 0);
			step_phase++;
		end
		o.word = it.cw;
		if (do_xor) begin
			o.word = it.cw ^ keystream[ks_index];
			ks_index++;
		end
		if (file_pos < CSUM_WORDS) csum ^= o.word;
		if (file_pos < XOR_ALL) file_pos++;
		o.absent = 1'b0;
		o.match = it.last && csum == csum_target;
		return o;
	endfunction

	// Queue one file; a good checksum comes from the table as it stands now
	function automatic int queue_file(int len, bit good_sum);
		cipher_item_t it;
		logic [31:0] s;
		cipher_item_t words[$];
		s = '0;
		if (!keys_missing() && !keystream_built) expand_keystream();
		for (int p = 0; p < len; p++) begin
			it.cw = $urandom;
			it.first = (p == 0);
			it.last = (p == len - 1);
			it.esum = $urandom;
			if (p < CSUM_WORDS) s ^= it.cw ^ keystream[p];
			words.push_back(it);
		end
		if (good_sum) words[0].esum = s;
		foreach (words[i]) pending_words.push_back(words[i]);
		return len;
	endfunction

	function automatic void queue_word(logic [31:0] cw, bit first, bit last,
			logic [31:0] esum);
		cipher_item_t it;
		it.cw = cw;
		it.first = first;
		it.last = last;
		it.esum = esum;
		pending_words.push_back(it);
	endfunction

	// Random files, some long, with a little noise in between
	function automatic void queue_random(int n);
		int cnt;
		int r;
		int len;
		cnt = 0;
		while (cnt < n) begin
			r = $urandom_range(0, 99);
			if (r < 85) begin
				r = $urandom_range(0, 99);
				if (r < 85) len = $urandom_range(1, 40);
				else if (r < 97) len = $urandom_range(41, 300);
				else len = $urandom_range(500, 700);
				cnt += queue_file(len, $urandom_range(0, 1));
			end else begin
				len = $urandom_range(1, 5);
				for (int i = 0; i < len; i++)
					queue_word($urandom, $urandom_range(0, 1), $urandom_range(0, 1), $urandom);
				cnt += len;
			end
		end
	endfunction

	function automatic int draw_gap();
		if (quiet || $urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 9);
	endfunction

	// Sender: present pending items, hold until taken, idle at random
	int in_gap = 0;
	cipher_item_t on_bus;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				plain_expected.push_back(decode_word(on_bus));
				in_gap = draw_gap();
			end
			if (in_valid && !in_ready) begin
				// hold
			end else if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				on_bus = pending_words.pop_front();
				cipher_word <= on_bus.cw;
				first_of_file <= on_bus.first;
				last_of_file <= on_bus.last;
				expected_sum <= on_bus.esum;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: check each result, stall at random, long hold on request
	int out_stall = 0;
	int hold_seen = 0;
	always @(posedge clk or negedge arst_n) begin
		plain_item_t x;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (plain_expected.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, word %h", $time, plain_word);
				end else begin
					x = plain_expected.pop_front();
					if (plain_word !== x.word) begin
						errors++;
						$display("%0t: plain_word exp %h got %h", $time, x.word, plain_word);
					end
					if (end_of_file !== x.eof) begin
						errors++;
						$display("%0t: end_of_file exp %b got %b", $time, x.eof, end_of_file);
					end
					if (key_absent !== x.absent) begin
						errors++;
						$display("%0t: key_absent exp %b got %b", $time, x.absent, key_absent);
					end
					if (sum_matches !== x.match) begin
						errors++;
						$display("%0t: sum_matches exp %b got %b", $time, x.match, sum_matches);
					end
				end
				out_stall = draw_gap();
			end
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				out_stall = 400;
			end
			if (out_stall > 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_words.size() != 0 || in_valid || plain_expected.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_key(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		key_word[idx] = val;
		keystream_built = 0;
	endtask

	// Stimulus and phases
	initial begin
		foreach (key_word[i]) key_word[i] = '0;
		keystream_built = 0;
		file_pos = '0;
		step_phase = '0;
		ks_index = '0;
		csum = '0;
		csum_target = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// No key loaded yet
		queue_word(32'h0, 1, 0, 32'h0);
		queue_word(32'hffffffff, 0, 1, 32'hffffffff);
		queue_word($urandom, 1, 1, $urandom);
		wait_drained();

		// Extreme keys, short directed files
		write_key(REG_KEY_A, 32'h00000001);
		write_key(REG_KEY_B, 32'hffffffff);
		write_key(REG_KEY_C, 32'h80000000);
		write_key(REG_KEY_D, 32'h7fffffff);
		void'(queue_file(1, 1));
		void'(queue_file(1, 0));
		queue_word(32'h0, 1, 0, 32'hffffffff);
		queue_word(32'hffffffff, 0, 0, 32'h0);
		queue_word($urandom, 0, 1, $urandom);
		queue_word($urandom, 0, 0, $urandom);
		queue_word($urandom, 0, 1, $urandom);
		void'(queue_file(4, 1));
		void'(queue_file(130, 1));
		queue_random(300);
		wait_drained();

		// Random keys; fill the block under a long output hold, then drain mid-phase
		write_key(REG_KEY_A, $urandom | 32'h1);
		write_key(REG_KEY_B, $urandom | 32'h1);
		write_key(REG_KEY_C, $urandom | 32'h1);
		write_key(REG_KEY_D, $urandom | 32'h1);
		queue_random(200);
		hold_seq++;
		wait_drained();
		queue_random(200);
		wait_drained();

		// One key zero, then restore it
		write_key(REG_KEY_C, 32'h0);
		void'(queue_file(3, 1));
		queue_word($urandom, 0, 0, $urandom);
		wait_drained();
		write_key(REG_KEY_C, 32'hffffffff);

		// One file well past the full span, into the strided part, no idling
		quiet = 1;
		void'(queue_file(XOR_ALL + 3 * STEP_WORDS + 10, 1));
		wait_drained();
		quiet = 0;
		queue_random(200);
		wait_drained();
		repeat (20) @(posedge clk);

		if (errors == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	// Watchdog
	initial begin
		#6ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
